// ===== rtl/srcif_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// srcif_pkg
// shared widths, register codes, limit tables and queue entry type for the
// sensor range clamp / iir filter core
// ---------------------------------------------------------------------------
package srcif_pkg;

  localparam int CH_W          = 4;
  localparam int RAW_W         = 24;
  localparam int HIST_W        = 18;
  localparam int CNT_W         = 32;
  localparam int ALPHA_W       = 8;
  localparam int EN_W          = 12;
  localparam int MAX_CHANNELS  = 16;
  localparam int NUM_CHANNELS_DEF = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;
  localparam int QUEUE_DEPTH   = 2;

  // datapath widths: |weighted sum| stays below 2**27
  localparam int PROD_W        = ALPHA_W + 1 + HIST_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int MAG_W         = SUM_W;
  localparam int DIV_STEPS     = MAG_W / 2;

  localparam int HIST_MAX_I    = (1 << (HIST_W - 1)) - 1;
  localparam int HIST_MIN_I    = -(1 << (HIST_W - 1));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_DEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CH_ENABLE = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_NUM_RST = 8'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_DEN_RST = 8'd10;
  localparam logic [EN_W-1:0]    CH_ENABLE_RST = 12'd7;

  typedef logic signed [HIST_W-1:0] hist_t;

  // one classified reading, front to back
  typedef struct packed {
    logic [CH_W-1:0] channel;
    hist_t           clamped;
    logic            ok;
    logic            last;
    logic            enabled;
    logic            in_range;
    logic            in_table;
  } item_t;

  function automatic hist_t lo_limit(input logic [CH_W-1:0] ch);
    hist_t v;
    unique case (ch) inside
      4'd0:              v = -18'sd4000;
      4'd1:              v = 18'sd0;
      4'd2:              v = 18'sd3000;
      4'd3, 4'd4, 4'd5:  v = -18'sd10000;
      4'd6, 4'd7, 4'd8:  v = -18'sd25000;
      default:           v = -18'sd40000;
    endcase
    return v;
  endfunction

  function automatic hist_t hi_limit(input logic [CH_W-1:0] ch);
    hist_t v;
    unique case (ch) inside
      4'd0:              v = 18'sd8500;
      4'd1:              v = 18'sd10000;
      4'd2:              v = 18'sd11000;
      4'd3, 4'd4, 4'd5:  v = 18'sd10000;
      4'd6, 4'd7, 4'd8:  v = 18'sd25000;
      default:           v = 18'sd40000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/srcif_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// srcif_front
// accepts readings, checks channel enable and range, clamps into the queue
// ---------------------------------------------------------------------------
module srcif_front #(
  parameter int NUM_CHANNELS = srcif_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [srcif_pkg::CH_W-1:0]    channel,
  input  wire logic signed [srcif_pkg::RAW_W-1:0] raw_sample,
  input  wire logic                          sensor_ok,
  input  wire logic                          last_in_cycle,
  input  wire logic [srcif_pkg::EN_W-1:0]    ch_enable,
  input  wire logic                          q_full,
  output logic                               q_push,
  output srcif_pkg::item_t                   q_item
);
  import srcif_pkg::*;

  logic [MAX_CHANNELS-1:0]  en_pad;
  hist_t                    lo;
  hist_t                    hi;
  logic signed [RAW_W-1:0]  lo_ext;
  logic signed [RAW_W-1:0]  hi_ext;
  logic                     below;
  logic                     above;
  logic                     in_table;

  assign en_pad   = {{(MAX_CHANNELS - EN_W){1'b0}}, ch_enable};
  assign in_table = {1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS);
  assign lo       = lo_limit(channel);
  assign hi       = hi_limit(channel);
  assign lo_ext   = {{(RAW_W - HIST_W){lo[HIST_W-1]}}, lo};
  assign hi_ext   = {{(RAW_W - HIST_W){hi[HIST_W-1]}}, hi};
  assign below    = raw_sample < lo_ext;
  assign above    = raw_sample > hi_ext;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_item.channel  = channel;
    q_item.ok       = sensor_ok;
    q_item.last     = last_in_cycle;
    q_item.in_table = in_table;
    q_item.enabled  = in_table & en_pad[channel];
    q_item.in_range = ~below & ~above;
    // limits fit the history width, so an in-range raw value does too
    if (below) begin
      q_item.clamped = lo;
    end else if (above) begin
      q_item.clamped = hi;
    end else begin
      q_item.clamped = raw_sample[HIST_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/srcif_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// srcif_queue
// short fifo of classified readings between front and back
// ---------------------------------------------------------------------------
module srcif_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire srcif_pkg::item_t push_item,
  output logic             full,
  input  wire logic        pop,
  output srcif_pkg::item_t pop_item,
  output logic             empty
);
  import srcif_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push & ~pop) begin
        count <= count + 1'b1;
      end else if (pop & ~push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/srcif_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// srcif_back
// per-channel iir update: shared multiplier, 2-bit-per-cycle divider,
// channel state and the registered result beat
// ---------------------------------------------------------------------------
module srcif_back #(
  parameter int NUM_CHANNELS = srcif_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [srcif_pkg::ALPHA_W-1:0] coef_num,
  input  wire logic [srcif_pkg::ALPHA_W-1:0] coef_den,
  input  wire logic [srcif_pkg::EN_W-1:0]    ch_enable,
  input  wire logic                          q_empty,
  input  wire srcif_pkg::item_t              q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [srcif_pkg::CH_W-1:0]         out_channel,
  output logic signed [srcif_pkg::HIST_W-1:0] filtered_value,
  output logic                               reading_valid,
  output logic                               report_failure,
  output logic [srcif_pkg::CNT_W-1:0]        cycles_done,
  output logic                               all_ready
);
  import srcif_pkg::*;

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULA = 3'd1;
  localparam logic [2:0] S_MULB = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]               state;
  item_t                    cur;
  logic signed [PROD_W-1:0] term_a;
  logic signed [PROD_W-1:0] term_b;
  logic                     neg;
  logic [MAG_W-1:0]         quo;
  logic [ALPHA_W-1:0]       rem;
  logic [STEP_W-1:0]        step;
  hist_t                    hist [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  valid;
  logic                     armed;
  logic [CNT_W-1:0]         counter;

  logic [IDX_W-1:0]          idx;
  logic signed [ALPHA_W:0]   mul_a;
  hist_t                     mul_b;
  logic signed [PROD_W-1:0]  product;
  logic signed [SUM_W-1:0]   sum_c;
  logic [ALPHA_W-1:0]        divisor;
  logic [ALPHA_W:0]          rs1;
  logic [ALPHA_W:0]          rs2;
  logic [ALPHA_W:0]          d1;
  logic [ALPHA_W:0]          d2;
  logic                      qb1;
  logic                      qb2;
  logic [ALPHA_W-1:0]        r1;
  logic [ALPHA_W-1:0]        r2;
  logic signed [SUM_W:0]     qs;
  hist_t                     hist_new;
  logic                      upd;
  logic                      fail;
  logic [NUM_CHANNELS-1:0]   valid_next;
  logic [MAX_CHANNELS-1:0]   en_pad;
  logic                      ready_c;
  logic                      commit;

  assign idx     = cur.in_table ? cur.channel[IDX_W-1:0] : '0;
  assign upd     = cur.enabled & cur.ok;
  assign fail    = cur.enabled & ~cur.ok;
  assign en_pad  = {{(MAX_CHANNELS - EN_W){1'b0}}, ch_enable};
  assign q_pop   = (state == S_IDLE) & ~q_empty;
  assign commit  = (state == S_DONE) & (~out_valid | ~out_stall);

  // shared multiplier: num * x, then (den - num) * prev
  assign mul_a   = (state == S_MULA) ? $signed({1'b0, coef_num})
                                     : $signed({1'b0, coef_den} - {1'b0, coef_num});
  assign mul_b   = (state == S_MULA) ? cur.clamped : hist[idx];
  assign product = mul_a * mul_b;

  assign sum_c   = SUM_W'(term_a) + SUM_W'(term_b)
                 + $signed({{(SUM_W - ALPHA_W + 1){1'b0}}, coef_den[ALPHA_W-1:1]});

  // zero denominator divides by one
  assign divisor = (coef_den == '0) ? ALPHA_W'(1) : coef_den;

  // two restoring division steps per cycle
  always_comb begin
    rs1 = {rem, quo[MAG_W-1]};
    d1  = rs1 - {1'b0, divisor};
    qb1 = rs1 >= {1'b0, divisor};
    r1  = qb1 ? d1[ALPHA_W-1:0] : rs1[ALPHA_W-1:0];
    rs2 = {r1, quo[MAG_W-2]};
    d2  = rs2 - {1'b0, divisor};
    qb2 = rs2 >= {1'b0, divisor};
    r2  = qb2 ? d2[ALPHA_W-1:0] : rs2[ALPHA_W-1:0];
  end

  // sign restore and saturation
  always_comb begin
    qs = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (qs > (SUM_W + 1)'(HIST_MAX_I)) begin
      hist_new = hist_t'(HIST_MAX_I);
    end else if (qs < (SUM_W + 1)'(HIST_MIN_I)) begin
      hist_new = hist_t'(HIST_MIN_I);
    end else begin
      hist_new = qs[HIST_W-1:0];
    end
  end

  always_comb begin
    valid_next = valid;
    if (cur.enabled) begin
      valid_next[idx] = cur.ok & cur.in_range;
    end
    ready_c = 1'b1;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (en_pad[i] && !valid_next[i]) begin
        ready_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
      armed     <= 1'b1;
      counter   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hist[i] <= '0;
      end
    end else begin
      out_valid <= commit | (out_valid & out_stall);
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= (q_item.enabled & q_item.ok) ? S_MULA : S_DONE;
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_SUM;
        S_SUM:  state <= S_DIV;
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            state <= S_IDLE;
            valid <= valid_next;
            if (upd) begin
              hist[idx] <= hist_new;
            end
            if (cur.last) begin
              counter <= counter + 1'b1;
              armed   <= 1'b1;
            end else if (fail) begin
              armed   <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_MULA) begin
      term_a <= product;
    end
    if (state == S_MULB) begin
      term_b <= product;
    end
    if (state == S_SUM) begin
      neg  <= sum_c[SUM_W-1];
      quo  <= sum_c[SUM_W-1] ? MAG_W'(-sum_c) : MAG_W'(sum_c);
      rem  <= '0;
      step <= '0;
    end
    if (state == S_DIV) begin
      quo  <= {quo[MAG_W-3:0], qb1, qb2};
      rem  <= r2;
      step <= step + 1'b1;
    end
    if (commit) begin
      out_channel    <= cur.channel;
      filtered_value <= !cur.in_table ? '0 : (upd ? hist_new : hist[idx]);
      reading_valid  <= cur.in_table & valid_next[idx];
      report_failure <= fail & armed;
      cycles_done    <= cur.last ? counter + 1'b1 : counter;
      all_ready      <= ready_c;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sensor_range_clamp_iir_filter_core.sv =====
`default_nettype none
// path: a reading that skips the filter is popped and goes to the result register;
//   a filtered reading goes through pop, two multiplies, sum, divider and result;
//   output stalls add to both
// the back end works on one reading at a time, start to finish
// reset: histories and valid bits zero, failure report armed, counter zero,
//   alpha 1/10, channels 0..2 enabled; queue of 2 readings empty
// ---------------------------------------------------------------------------
// sensor_range_clamp_iir_filter_core
// per-channel range check, clamp and first-order iir smoothing of sensor
// readings, with poll cycle counting and failure reporting
// ---------------------------------------------------------------------------
module sensor_range_clamp_iir_filter_core #(
  parameter int NUM_CHANNELS = srcif_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // reading channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [srcif_pkg::CH_W-1:0]         channel,
  input  wire logic signed [srcif_pkg::RAW_W-1:0] raw_sample,
  input  wire logic                               sensor_ok,
  input  wire logic                               last_in_cycle,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [srcif_pkg::CH_W-1:0]              out_channel,
  output logic signed [srcif_pkg::HIST_W-1:0]     filtered_value,
  output logic                                    reading_valid,
  output logic                                    report_failure,
  output logic [srcif_pkg::CNT_W-1:0]             cycles_done,
  output logic                                    all_ready,
  // register write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [srcif_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srcif_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import srcif_pkg::*;

  logic [ALPHA_W-1:0] coef_num;
  logic [ALPHA_W-1:0] coef_den;
  logic [EN_W-1:0]    ch_enable;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t push_item;
  item_t pop_item;

  // register writes are always accepted and take effect at the accepting edge
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_num  <= ALPHA_NUM_RST;
      coef_den  <= ALPHA_DEN_RST;
      ch_enable <= CH_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA_NUM: coef_num  <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_DEN: coef_den  <= cfg_data[ALPHA_W-1:0];
        REG_CH_ENABLE: ch_enable <= cfg_data[EN_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // front: accept the beat, classify against enable and range table, clamp
  srcif_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel       (channel),
    .raw_sample    (raw_sample),
    .sensor_ok     (sensor_ok),
    .last_in_cycle (last_in_cycle),
    .ch_enable     (ch_enable),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // decoupling queue so the front keeps taking beats while the back divides, until it is full
  srcif_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // back: filter arithmetic, channel state, result register
  srcif_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .coef_num       (coef_num),
    .coef_den       (coef_den),
    .ch_enable      (ch_enable),
    .q_empty        (q_empty),
    .q_item         (pop_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .filtered_value (filtered_value),
    .reading_valid  (reading_valid),
    .report_failure (report_failure),
    .cycles_done    (cycles_done),
    .all_ready      (all_ready)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: sensor range clamp / iir filter core testbench
// drives sensor readings through the core, predicts every result beat with
// an independent per-channel range check, clamp and smoothing calculation,
// and compares each beat field by field; register settings are changed
// between phases while the core is idle, and both sides stall at random
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srcif_pkg::*;

  localparam int NCH             = NUM_CHANNELS_DEF;
  localparam int WATCHDOG_LIMIT  = 2000;   // beat-free cycles before giving up
  localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
  localparam int DRAIN_CYCLES    = 40;     // settle time after the last beat
  localparam int RANDOM_READINGS = 1000;   // readings on enabled channels
  localparam int PHASE_READINGS  = 120;
  localparam int QUIET_TAIL      = 150;    // final stretch with no idling
  localparam longint FILT_MAX    = 131071;
  localparam longint FILT_MIN    = -131072;

  // index 3 is not a register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // fixed per-channel acceptance window
  localparam int RANGE_LO [NCH] = '{-4000, 0, 3000, -10000, -10000, -10000,
                                    -25000, -25000, -25000, -40000, -40000, -40000};
  localparam int RANGE_HI [NCH] = '{8500, 10000, 11000, 10000, 10000, 10000,
                                    25000, 25000, 25000, 40000, 40000, 40000};

  typedef struct {
    logic [CH_W-1:0]         channel;
    logic signed [RAW_W-1:0] raw;
    logic                    ok;
    logic                    last;
  } reading_t;

  typedef struct {
    logic [CH_W-1:0]  channel;
    hist_t            fval;
    logic             valid;
    logic             report;
    logic [CNT_W-1:0] cycles;
    logic             ready;
  } result_t;

  // -------------------------------------------------------------------------
  // smoothing scoreboard: own copy of the channel state and the registers,
  // one expected beat per accepted reading, oldest first
  // -------------------------------------------------------------------------
  class smoothing_scoreboard;
    logic [ALPHA_W-1:0] weight_num;
    logic [ALPHA_W-1:0] weight_den;
    logic [EN_W-1:0]    enabled;
    hist_t              history [NCH];
    bit                 valid_bits [NCH];
    bit                 report_armed;
    logic [CNT_W-1:0]   poll_count;
    result_t            pending_results [$];
    int mismatches, checked, readings, cfg_writes;
    int reports, out_of_range, saturated, ready_beats;

    function new();
      weight_num   = 8'd1;
      weight_den   = 8'd10;
      enabled      = 12'h007;
      foreach (history[i]) begin
        history[i]    = '0;
        valid_bits[i] = 1'b0;
      end
      report_armed = 1'b1;
      poll_count   = '0;
      mismatches   = 0;
      checked      = 0;
      readings     = 0;
      cfg_writes   = 0;
      reports      = 0;
      out_of_range = 0;
      saturated    = 0;
      ready_beats  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      cfg_writes++;
      case (idx)
        REG_ALPHA_NUM: weight_num = data[ALPHA_W-1:0];
        REG_ALPHA_DEN: weight_den = data[ALPHA_W-1:0];
        REG_CH_ENABLE: enabled    = data[EN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit channel_live(int ch);
      if (ch >= NCH) return 1'b0;
      return enabled[ch];
    endfunction

    // weighted sum with rounding term, divide toward zero, saturate to 18 bits
    function hist_t smooth(longint x, hist_t prev);
      longint num, den, p, sum, q;
      num = weight_num;
      den = weight_den;
      p   = prev;
      sum = num * x + (den - num) * p + den / 2;
      q   = sum / ((den == 0) ? 1 : den);
      if (q > FILT_MAX) begin
        q = FILT_MAX;
        saturated++;
      end
      if (q < FILT_MIN) begin
        q = FILT_MIN;
        saturated++;
      end
      return hist_t'(q);
    endfunction

    function void note_reading(reading_t rd);
      result_t want;
      int      ch;
      longint  x;
      ch          = rd.channel;
      want.report = 1'b0;
      readings++;
      if (channel_live(ch)) begin
        if (!rd.ok) begin
          // driver failure keeps the history, drops the valid bit
          valid_bits[ch] = 1'b0;
          if (report_armed) begin
            report_armed = 1'b0;
            want.report  = 1'b1;
            reports++;
          end
        end else begin
          x = rd.raw;
          valid_bits[ch] = (x >= RANGE_LO[ch]) && (x <= RANGE_HI[ch]);
          if (!valid_bits[ch]) out_of_range++;
          if (x < RANGE_LO[ch]) x = RANGE_LO[ch];
          if (x > RANGE_HI[ch]) x = RANGE_HI[ch];
          history[ch] = smooth(x, history[ch]);
        end
      end
      want.channel = rd.channel;
      if (ch < NCH) begin
        want.fval  = history[ch];
        want.valid = valid_bits[ch];
      end else begin
        want.fval  = '0;
        want.valid = 1'b0;
      end
      // the commit mark counts even on ignored channels
      if (rd.last) begin
        poll_count++;
        report_armed = 1'b1;
      end
      want.cycles = poll_count;
      want.ready  = 1'b1;
      for (int i = 0; i < NCH; i++) begin
        if (enabled[i] && !valid_bits[i]) want.ready = 1'b0;
      end
      if (want.ready) ready_beats++;
      pending_results.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: ch %0d value %0d",
                   $time, got.channel, got.fval);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.channel !== want.channel || got.fval !== want.fval ||
          got.valid !== want.valid || got.report !== want.report ||
          got.cycles !== want.cycles || got.ready !== want.ready) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch (expected/actual) ch %0d/%0d value %0d/%0d",
                   $time, want.channel, got.channel, want.fval, got.fval);
          $display("  valid %b/%b report %b/%b cycles %0d/%0d ready %b/%b",
                   want.valid, got.valid, want.report, got.report,
                   want.cycles, got.cycles, want.ready, got.ready);
        end
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // clock, reset and the core
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  logic                    in_valid;
  logic                    in_stall;
  logic [CH_W-1:0]         channel;
  logic signed [RAW_W-1:0] raw_sample;
  logic                    sensor_ok;
  logic                    last_in_cycle;
  logic                    out_valid;
  logic                    out_stall;
  logic [CH_W-1:0]         out_channel;
  logic signed [HIST_W-1:0] filtered_value;
  logic                    reading_valid;
  logic                    report_failure;
  logic [CNT_W-1:0]        cycles_done;
  logic                    all_ready;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  smoothing_scoreboard sb;

  // idling knobs shared between the sender and the receiver
  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  always #1 clk = ~clk;

  sensor_range_clamp_iir_filter_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .channel        (channel),
    .raw_sample     (raw_sample),
    .sensor_ok      (sensor_ok),
    .last_in_cycle  (last_in_cycle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .filtered_value (filtered_value),
    .reading_valid  (reading_valid),
    .report_failure (report_failure),
    .cycles_done    (cycles_done),
    .all_ready      (all_ready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // -------------------------------------------------------------------------
  // result side: check every accepted beat, values as seen before the edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.channel = out_channel;
      got.fval    = filtered_value;
      got.valid   = reading_valid;
      got.report  = report_failure;
      got.cycles  = cycles_done;
      got.ready   = all_ready;
      sb.check_result(got);
    end
  end

  // receiver stall: random bursts, plus one long hold-off on request
  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: any accepted beat on any channel restarts the count
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results still due",
             WATCHDOG_LIMIT, sb.pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // sender tasks: every call starts and ends at a rising edge
  // -------------------------------------------------------------------------

  // one reading beat, with an optional random gap in front of it
  task automatic send_reading(input logic [CH_W-1:0] ch, input logic signed [RAW_W-1:0] raw,
                              input logic ok, input logic last);
    int       gap;
    reading_t rd;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    channel       <= ch;
    raw_sample    <= raw;
    sensor_ok     <= ok;
    last_in_cycle <= last;
    do @(posedge clk); while (in_stall);
    rd = '{ch, raw, ok, last};
    sb.note_reading(rd);
  endtask

  // register writes once every expected beat has come back; alpha writes
  // carry junk in the unused upper data bits
  task automatic program_filter(input logic [ALPHA_W-1:0] num, input logic [ALPHA_W-1:0] den,
                                input logic [EN_W-1:0] en, input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx [$];
    logic [CFG_DATA_W-1:0] dat [$];
    logic [3:0]            pad;
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    pad = 4'($urandom);
    idx.push_back(REG_ALPHA_NUM);
    dat.push_back({pad, num});
    pad = 4'($urandom);
    idx.push_back(REG_ALPHA_DEN);
    dat.push_back({pad, den});
    idx.push_back(REG_CH_ENABLE);
    dat.push_back(en);
    if (poke_spare) begin
      idx.push_back(REG_SPARE);
      dat.push_back(CFG_DATA_W'($urandom));
    end
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], dat[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // raw value around the channel window, now and then anywhere in 24 bits
  function automatic logic signed [RAW_W-1:0] pick_raw(int ch);
    int lo, hi, sel, v;
    lo  = RANGE_LO[ch];
    hi  = RANGE_HI[ch];
    sel = $urandom_range(0, 99);
    if (sel < 60)      v = lo + int'($urandom_range(0, hi - lo));
    else if (sel < 70) v = lo - int'($urandom_range(1, 2000));
    else if (sel < 80) v = hi + int'($urandom_range(1, 2000));
    else if (sel < 85) v = lo;
    else if (sel < 90) v = hi;
    else if (sel < 97) v = $urandom;
    else               v = sel[0] ? 24'h7FFFFF : -8388608;
    return RAW_W'(v);
  endfunction

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [ALPHA_W-1:0] num, den;
    logic [EN_W-1:0]    live_mask;
    logic [CH_W-1:0]    ch;
    int                 poll [$];
    int                 effective, phase_done, phase;
    bit                 quiet;

    sb = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    channel       = '0;
    raw_sample    = '0;
    sensor_ok     = 1'b0;
    last_in_cycle = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ALPHA_NUM;
    cfg_data      = '0;
    gap_pct       = 15;
    stall_pct     = 15;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, channels 0..2 live
    send_reading(4'd0, 0, 1'b1, 1'b0);
    send_reading(4'd0, 24'h7FFFFF, 1'b1, 1'b0);   // top of raw range, clamped high
    send_reading(4'd0, 24'h800000, 1'b1, 1'b0);   // bottom of raw range, clamped low
    send_reading(4'd0, -5000, 1'b1, 1'b0);        // negative sum, truncation toward zero
    send_reading(4'd1, -1, 1'b1, 1'b0);           // one below the window
    send_reading(4'd1, 0, 1'b1, 1'b0);            // window floor exactly
    send_reading(4'd2, 11001, 1'b1, 1'b0);        // one above the window
    send_reading(4'd0, 8500, 1'b1, 1'b0);
    send_reading(4'd2, 3000, 1'b1, 1'b1);         // all live channels valid, commit
    send_reading(4'd2, 5000, 1'b0, 1'b0);         // first driver failure reports
    send_reading(4'd1, 10000, 1'b0, 1'b0);        // second one in the cycle does not
    send_reading(4'd3, 1234, 1'b1, 1'b0);         // disabled channel ignored
    send_reading(4'd4, 0, 1'b0, 1'b1);            // disabled failure still commits
    send_reading(4'd12, 100, 1'b1, 1'b0);         // past the channel count
    send_reading(4'd15, -100, 1'b0, 1'b1);
    send_reading(4'd0, 0, 1'b0, 1'b1);            // failure and commit in one beat

    // numerator above denominator: negative weight on history, saturation
    program_filter(8'd255, 8'd1, 12'hFFF, 1'b1);
    send_reading(4'd9, 40000, 1'b1, 1'b0);
    send_reading(4'd9, 24'h7FFFFF, 1'b1, 1'b0);
    send_reading(4'd9, -40000, 1'b1, 1'b0);
    send_reading(4'd11, 0, 1'b1, 1'b1);

    // zero denominator acts as one with no rounding term
    program_filter(8'd3, 8'd0, 12'hFFF, 1'b0);
    send_reading(4'd10, 777, 1'b1, 1'b0);
    send_reading(4'd10, -777, 1'b1, 1'b1);

    // nothing enabled, zero weight
    program_filter(8'd0, 8'd255, 12'h000, 1'b0);
    send_reading(4'd5, 100, 1'b1, 1'b1);
    send_reading(4'd0, 100, 1'b0, 1'b1);

    // random phases: mostly well-formed poll cycles over the live channels,
    // some stray beats, fresh settings per phase
    effective = 0;
    phase     = 0;
    while (effective < RANDOM_READINGS) begin
      quiet = (effective >= RANDOM_READINGS - QUIET_TAIL);
      case ($urandom_range(0, 5))
        0:       num = 8'd0;
        1:       num = 8'd255;
        2:       num = ALPHA_W'($urandom);
        default: num = ALPHA_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 7))
        0:       den = 8'd0;
        1:       den = 8'd1;
        2:       den = 8'd255;
        default: den = ALPHA_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 9))
        0:       live_mask = 12'h000;
        1, 2:    live_mask = 12'hFFF;
        3:       live_mask = 12'h001;
        4:       live_mask = 12'h800;
        default: live_mask = EN_W'($urandom);
      endcase
      program_filter(num, den, live_mask, 1'b0);

      // idling varies by phase, none at all near the end
      if (quiet || phase % 3 == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (phase % 3 == 1) begin
        gap_pct   = 20;
        stall_pct = 20;
      end else begin
        gap_pct   = 40;
        stall_pct = 8;
      end
      // back-pressure: receiver holds off while the sender keeps pushing
      if (phase == 1) begin
        gap_pct      = 0;
        hold_request = 1'b1;
      end

      if (live_mask == '0) begin
        repeat (20)
          send_reading(CH_W'($urandom), RAW_W'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        phase_done = 0;
        while (phase_done < PHASE_READINGS && effective < RANDOM_READINGS) begin
          // the tail of the run goes without idling even mid-phase
          if (effective >= RANDOM_READINGS - QUIET_TAIL) begin
            gap_pct   = 0;
            stall_pct = 0;
          end
          if ($urandom_range(0, 99) < 15) begin
            // stray beat, any channel and any bits
            ch = CH_W'($urandom);
            send_reading(ch, RAW_W'($urandom), 1'($urandom), 1'($urandom));
            if (ch < NCH && live_mask[ch]) begin
              effective++;
              phase_done++;
            end
          end else begin
            poll.delete();
            for (int i = 0; i < NCH; i++) begin
              if (live_mask[i] && $urandom_range(0, 9) != 0) poll.push_back(i);
            end
            foreach (poll[i]) begin
              // a few cycles lose their commit mark
              send_reading(CH_W'(poll[i]), pick_raw(poll[i]), $urandom_range(0, 19) != 0,
                           (i == poll.size() - 1) && $urandom_range(0, 19) != 0);
            end
            effective  += poll.size();
            phase_done += poll.size();
          end
        end
      end
      phase++;
    end

    // drain
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run summary: %0d readings over %0d phases, %0d beats checked, %0d register writes",
             sb.readings, phase, sb.checked, sb.cfg_writes);
    $display("seen: %0d failure reports, %0d out-of-window readings, %0d saturations, %0d all-ready",
             sb.reports, sb.out_of_range, sb.saturated, sb.ready_beats);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srcif_pkg.sv
rtl/srcif_front.sv
rtl/srcif_queue.sv
rtl/srcif_back.sv
rtl/sensor_range_clamp_iir_filter_core.sv
tb/tb_top.sv
